// ----- rtl/core/crfe_pkg.sv -----
// Shared types and constants for the clipped rectangle fill engine.
// Used by crfe_walk and clipped_rect_fill_engine; depends on nothing.
package crfe_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int STRIDE_BITS_DEF = 24;
  localparam int SIZE_BITS_DEF   = 40;
  localparam int ADDR_BITS_DEF   = 48;

  localparam int OP_BITS        = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int BPP_BITS       = 4;
  localparam int COLOR_BITS     = 32;
  localparam int BCOUNT_BITS    = 3;

  localparam logic [BPP_BITS-1:0] BPP_RESET = 4'd4;

  typedef enum logic [OP_BITS-1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_FILL  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_ADDRESS    = 3'd0,
    REG_BUFFER_SIZE     = 3'd1,
    REG_SCREEN_WIDTH    = 3'd2,
    REG_SCREEN_HEIGHT   = 3'd3,
    REG_ROW_STRIDE      = 3'd4,
    REG_PIXEL_BYTES     = 3'd5,
    REG_CONFIGURED      = 3'd6,
    REG_WRITES_ALLOWED  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic has_res;
    logic write_valid;
    logic done;
  } res_ctl_t;

endpackage

// ----- rtl/core/crfe_walk.sv -----
// Walk state and per-word step logic of the clipped rectangle fill engine.
// Depends on crfe_pkg; instantiated by clipped_rect_fill_engine.
module crfe_walk #(
  parameter int COORD_BITS  = crfe_pkg::COORD_BITS_DEF,
  parameter int STRIDE_BITS = crfe_pkg::STRIDE_BITS_DEF,
  parameter int SIZE_BITS   = crfe_pkg::SIZE_BITS_DEF,
  parameter int ADDR_BITS   = crfe_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step_en,
  input  crfe_pkg::op_t                      op,
  input  logic [COORD_BITS-1:0]              x,
  input  logic [COORD_BITS-1:0]              y,
  input  logic [COORD_BITS-1:0]              rect_width,
  input  logic [COORD_BITS-1:0]              rect_height,
  input  logic [crfe_pkg::COLOR_BITS-1:0]    color,
  input  logic [ADDR_BITS-1:0]               base_address,
  input  logic [SIZE_BITS-1:0]               buffer_size,
  input  logic [COORD_BITS-1:0]              screen_width,
  input  logic [COORD_BITS-1:0]              screen_height,
  input  logic [STRIDE_BITS-1:0]             row_stride,
  input  logic [crfe_pkg::BPP_BITS-1:0]      pixel_bytes,
  input  logic                               interlock,
  output crfe_pkg::res_ctl_t                 res,
  output logic [ADDR_BITS-1:0]               res_address,
  output logic [crfe_pkg::COLOR_BITS-1:0]    res_data,
  output logic [crfe_pkg::BCOUNT_BITS-1:0]   res_byte_count
);

  localparam int RW     = COORD_BITS + 1;
  localparam int PROD_W = RW + STRIDE_BITS;
  localparam int XO_W   = COORD_BITS + crfe_pkg::BPP_BITS;
  localparam int OFF_W  = ((PROD_W > SIZE_BITS) ? PROD_W : SIZE_BITS) + 2;
  localparam int AW2    = (OFF_W > ADDR_BITS) ? OFF_W : ADDR_BITS;

  logic                          busy_r, busy_nxt;
  logic [COORD_BITS-1:0]         first_col_r, first_col_nxt;
  logic [COORD_BITS-1:0]         cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0]         cur_row_r, cur_row_nxt;
  logic [RW-1:0]                 end_col_r, end_col_nxt;
  logic [RW-1:0]                 end_row_r, end_row_nxt;
  logic [crfe_pkg::COLOR_BITS-1:0] fill_r, fill_nxt;
  logic [SIZE_BITS-1:0]          row_off_r, row_off_nxt;

  logic                          is_tick, is_fill;
  logic [COORD_BITS-1:0]         rx, ry, rw, rh;
  logic [RW-1:0]                 next_row, row_sel, col_p1, rx_end, ry_end;
  logic [COORD_BITS-1:0]         col_sel;
  logic [PROD_W-1:0]             yo;
  logic [XO_W-1:0]               xo;
  logic [OFF_W-1:0]              roff, off, off_end, size_ext;
  logic                          fits, yo_past, refuse, adv_col, walk_done;
  logic                          wr, bpp_ok, wr_final;
  logic [AW2-1:0]                addr_full;
  logic [crfe_pkg::COLOR_BITS-1:0] src_color;
  crfe_pkg::res_ctl_t            res_pre;

  always_comb begin
    is_tick  = (op == crfe_pkg::OP_TICK);
    is_fill  = (op == crfe_pkg::OP_FILL);
    rx       = is_fill ? '0 : x;
    ry       = is_fill ? '0 : y;
    rw       = is_fill ? screen_width : rect_width;
    rh       = is_fill ? screen_height : rect_height;
    next_row = RW'(cur_row_r) + RW'(1);
    col_p1   = RW'(cur_col_r) + RW'(1);
    row_sel  = is_tick ? next_row : RW'(ry);
    col_sel  = is_tick ? cur_col_r : x;
    yo       = PROD_W'(row_sel) * PROD_W'(row_stride);
    xo       = XO_W'(col_sel) * XO_W'(pixel_bytes);
    size_ext = OFF_W'(buffer_size);
    roff     = is_tick ? OFF_W'(row_off_r) : OFF_W'(yo);
    off      = roff + OFF_W'(xo);
    off_end  = off + OFF_W'(pixel_bytes);
    fits     = (off_end <= size_ext);
    yo_past  = (OFF_W'(yo) >= size_ext);
    refuse   = !interlock || (rx >= screen_width) || (ry >= screen_height) ||
               (rw == '0) || (rh == '0) || yo_past;
    rx_end   = RW'(rx) + RW'(rw);
    ry_end   = RW'(ry) + RW'(rh);
    adv_col  = fits && (col_p1 < end_col_r);
    walk_done = !adv_col && ((next_row >= end_row_r) || yo_past);
  end

  always_comb begin
    busy_nxt      = busy_r;
    first_col_nxt = first_col_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    end_col_nxt   = end_col_r;
    end_row_nxt   = end_row_r;
    fill_nxt      = fill_r;
    row_off_nxt   = row_off_r;
    res_pre       = '0;
    wr            = 1'b0;
    src_color     = color;
    unique case (op)
      crfe_pkg::OP_PIXEL: begin
        if (!busy_r) begin
          res_pre.has_res = 1'b1;
          res_pre.done    = 1'b1;
          wr = interlock && (x < screen_width) && (y < screen_height) && fits;
        end
      end
      crfe_pkg::OP_RECT, crfe_pkg::OP_FILL: begin
        if (!busy_r) begin
          if (refuse) begin
            res_pre.has_res = 1'b1;
            res_pre.done    = 1'b1;
          end else begin
            busy_nxt      = 1'b1;
            first_col_nxt = rx;
            cur_col_nxt   = rx;
            cur_row_nxt   = ry;
            end_col_nxt   = (rx_end > RW'(screen_width)) ? RW'(screen_width) : rx_end;
            end_row_nxt   = (ry_end > RW'(screen_height)) ? RW'(screen_height) : ry_end;
            fill_nxt      = color;
            row_off_nxt   = SIZE_BITS'(yo);
          end
        end
      end
      crfe_pkg::OP_TICK: begin
        src_color = fill_r;
        if (busy_r) begin
          res_pre.has_res = 1'b1;
          res_pre.done    = walk_done;
          wr              = fits && interlock;
          if (adv_col) begin
            cur_col_nxt = col_p1[COORD_BITS-1:0];
          end else if (walk_done) begin
            busy_nxt = 1'b0;
          end else begin
            cur_row_nxt = next_row[COORD_BITS-1:0];
            cur_col_nxt = first_col_r;
            row_off_nxt = SIZE_BITS'(yo);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    bpp_ok = (pixel_bytes == crfe_pkg::BPP_BITS'(1)) ||
             (pixel_bytes == crfe_pkg::BPP_BITS'(2)) ||
             (pixel_bytes == crfe_pkg::BPP_BITS'(4));
    wr_final        = wr && bpp_ok;
    res             = res_pre;
    res.write_valid = wr_final;
    addr_full       = AW2'(base_address) + AW2'(off);
    res_address     = wr_final ? addr_full[ADDR_BITS-1:0] : '0;
    res_byte_count  = wr_final ? pixel_bytes[crfe_pkg::BCOUNT_BITS-1:0] : '0;
    res_data        = '0;
    if (wr_final) begin
      priority if (pixel_bytes == crfe_pkg::BPP_BITS'(1)) begin
        res_data = {24'd0, src_color[7:0]};
      end else if (pixel_bytes == crfe_pkg::BPP_BITS'(2)) begin
        res_data = {16'd0, src_color[15:0]};
      end else begin
        res_data = src_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (step_en) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      first_col_r <= first_col_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      end_col_r   <= end_col_nxt;
      end_row_r   <= end_row_nxt;
      fill_r      <= fill_nxt;
      row_off_r   <= row_off_nxt;
    end
  end

endmodule

// ----- rtl/core/clipped_rect_fill_engine.sv -----
// Top level of the clipped rectangle fill engine: stream ports, register file,
// input and result registers. Depends on crfe_pkg and crfe_walk.
//
// The engine takes one input word per clock unless the input stalls, and loads its
// result word, if any, from the input register into the output register. A result left
// waiting in the output register holds the word in the input register, so the
// input stalls once both registers are full. Outside a walk, a put-pixel word answers
// with one result and a rectangle or fill word answers only when refused; during a walk
// each tick word walks one position of the clipped rectangle. The step from the input
// register to the result register holds one row-by-stride multiplier, one
// column-by-pixel-size multiplier and the bounds compares against buffer_size.
module clipped_rect_fill_engine #(
  parameter int COORD_BITS  = crfe_pkg::COORD_BITS_DEF,
  parameter int STRIDE_BITS = crfe_pkg::STRIDE_BITS_DEF,
  parameter int SIZE_BITS   = crfe_pkg::SIZE_BITS_DEF,
  parameter int ADDR_BITS   = crfe_pkg::ADDR_BITS_DEF,
  localparam int IN_DATA_W  = ((4 * COORD_BITS + crfe_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((1 + ADDR_BITS + crfe_pkg::COLOR_BITS
                               + crfe_pkg::BCOUNT_BITS + 7) / 8) * 8,
  localparam int CFG_W      = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // x, y, rect_width, rect_height, color
  input  logic [IN_DATA_W-1:0]                in_tdata,
  // operation
  input  logic [crfe_pkg::OP_BITS-1:0]        in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // write_valid, address, data, byte_count
  output logic [OUT_DATA_W-1:0]               out_tdata,
  // done_res
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]                    cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int CL = crfe_pkg::COLOR_BITS;

  logic [ADDR_BITS-1:0]          base_r;
  logic [SIZE_BITS-1:0]          size_r;
  logic [CB-1:0]                 sw_r, sh_r;
  logic [STRIDE_BITS-1:0]        stride_r;
  logic [crfe_pkg::BPP_BITS-1:0] bpp_r;
  logic                          configured_r, allowed_r;

  logic                          in_valid_r;
  logic [IN_DATA_W-1:0]          in_data_r;
  logic [crfe_pkg::OP_BITS-1:0]  in_op_r;
  logic                          advance, step_en;

  crfe_pkg::res_ctl_t            res;
  logic [ADDR_BITS-1:0]          res_address;
  logic [CL-1:0]                 res_data;
  logic [crfe_pkg::BCOUNT_BITS-1:0] res_byte_count;

  logic                          out_valid_r;
  logic [OUT_DATA_W-1:0]         out_data_r;
  logic                          out_last_r;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign step_en    = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      size_r       <= '0;
      sw_r         <= '0;
      sh_r         <= '0;
      stride_r     <= '0;
      bpp_r        <= crfe_pkg::BPP_RESET;
      configured_r <= 1'b0;
      allowed_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (crfe_pkg::reg_idx_t'(cfg_index))
        crfe_pkg::REG_BASE_ADDRESS:    base_r       <= cfg_data[ADDR_BITS-1:0];
        crfe_pkg::REG_BUFFER_SIZE:     size_r       <= cfg_data[SIZE_BITS-1:0];
        crfe_pkg::REG_SCREEN_WIDTH:    sw_r         <= cfg_data[CB-1:0];
        crfe_pkg::REG_SCREEN_HEIGHT:   sh_r         <= cfg_data[CB-1:0];
        crfe_pkg::REG_ROW_STRIDE:      stride_r     <= cfg_data[STRIDE_BITS-1:0];
        crfe_pkg::REG_PIXEL_BYTES:     bpp_r        <= cfg_data[crfe_pkg::BPP_BITS-1:0];
        crfe_pkg::REG_CONFIGURED:      configured_r <= cfg_data[0];
        crfe_pkg::REG_WRITES_ALLOWED:  allowed_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  crfe_walk #(
    .COORD_BITS  (COORD_BITS),
    .STRIDE_BITS (STRIDE_BITS),
    .SIZE_BITS   (SIZE_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .op              (crfe_pkg::op_t'(in_op_r)),
    .x               (in_data_r[CB-1:0]),
    .y               (in_data_r[2*CB-1:CB]),
    .rect_width      (in_data_r[3*CB-1:2*CB]),
    .rect_height     (in_data_r[4*CB-1:3*CB]),
    .color           (in_data_r[4*CB+CL-1:4*CB]),
    .base_address    (base_r),
    .buffer_size     (size_r),
    .screen_width    (sw_r),
    .screen_height   (sh_r),
    .row_stride      (stride_r),
    .pixel_bytes     (bpp_r),
    .interlock       (configured_r && allowed_r),
    .res             (res),
    .res_address     (res_address),
    .res_data        (res_data),
    .res_byte_count  (res_byte_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res.has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= OUT_DATA_W'({res_byte_count, res_data, res_address, res.write_valid});
      out_last_r <= res.done;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for clipped_rect_fill_engine: directed and random command words,
// with a word-level predictor of the fill walk and a field-by-field check of each write.
// Depends on crfe_pkg and the engine RTL only.
module testbench;

  localparam int IN_W = ((4 * crfe_pkg::COORD_BITS_DEF + crfe_pkg::COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((1 + crfe_pkg::ADDR_BITS_DEF + crfe_pkg::COLOR_BITS
                           + crfe_pkg::BCOUNT_BITS + 7) / 8) * 8;
  localparam int CFG_W = (crfe_pkg::ADDR_BITS_DEF > crfe_pkg::SIZE_BITS_DEF) ?
                         crfe_pkg::ADDR_BITS_DEF : crfe_pkg::SIZE_BITS_DEF;
  localparam int ADDR_LSB = 1;
  localparam int DATA_LSB = ADDR_LSB + crfe_pkg::ADDR_BITS_DEF;
  localparam int CNT_LSB = DATA_LSB + crfe_pkg::COLOR_BITS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    crfe_pkg::op_t op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] color;
  } fill_cmd_t;

  typedef struct packed {
    logic        wr;
    logic [47:0] addr;
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        done;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  crfe_pkg::op_t in_tuser = crfe_pkg::OP_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  crfe_pkg::reg_idx_t cfg_index = crfe_pkg::REG_BASE_ADDRESS;
  logic [CFG_W-1:0] cfg_data = '0;

  // Register copies kept by the predictor.
  logic [63:0] reg_base = '0;
  logic [63:0] reg_size = '0;
  logic [63:0] reg_width = '0;
  logic [63:0] reg_height = '0;
  logic [63:0] reg_stride = '0;
  logic [63:0] reg_bpp = {60'b0, crfe_pkg::BPP_RESET};
  logic reg_configured = 1'b0;
  logic reg_allowed = 1'b0;

  // Walk state of the predictor.
  bit walk_busy = 1'b0;
  logic [63:0] walk_first_col = '0;
  logic [63:0] walk_col = '0;
  logic [63:0] walk_row = '0;
  logic [63:0] walk_end_col = '0;
  logic [63:0] walk_end_row = '0;
  logic [31:0] walk_color = '0;
  logic [63:0] walk_row_off = '0;

  fill_cmd_t cmd_queue[$];
  fb_write_t expected_writes[$];

  bit in_fire = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0] stall_pat = 8'hFF;
  int unsigned pat_left = 0;

  int unsigned items_queued = 0;
  int unsigned words_in = 0;
  int unsigned results_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned walks_ended = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  clipped_rect_fill_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit gate_open();
    return reg_configured && reg_allowed;
  endfunction

  function automatic bit pixel_fit(input logic [63:0] roff, input logic [63:0] col,
                                   output logic [63:0] off);
    logic [63:0] xo;
    logic [63:0] sum;
    off = '0;
    xo = col * reg_bpp;
    if (~roff < xo) return 1'b0;
    sum = roff + xo;
    if (sum > reg_size || reg_size - sum < reg_bpp) return 1'b0;
    off = sum;
    return 1'b1;
  endfunction

  function automatic fb_write_t make_write(input bit wr, input logic [63:0] off,
                                           input logic [31:0] color, input bit done);
    fb_write_t res;
    logic [63:0] sum;
    res = '0;
    if (wr && (reg_bpp == 1 || reg_bpp == 2 || reg_bpp == 4)) begin
      sum = reg_base + off;
      res.wr = 1'b1;
      res.addr = sum[47:0];
      res.cnt = reg_bpp[2:0];
      if (reg_bpp == 1) res.data = {24'b0, color[7:0]};
      else if (reg_bpp == 2) res.data = {16'b0, color[15:0]};
      else res.data = color;
    end
    res.done = done;
    return res;
  endfunction

  function automatic bit begin_walk(input logic [63:0] x, input logic [63:0] y,
                                    input logic [63:0] w, input logic [63:0] h,
                                    input logic [31:0] color, output fb_write_t res);
    logic [63:0] yo;
    res = '0;
    if (walk_busy) return 1'b0;
    if (!gate_open() || x >= reg_width || y >= reg_height || w == 0 || h == 0) begin
      res = make_write(1'b0, '0, '0, 1'b1);
      return 1'b1;
    end
    yo = y * reg_stride;
    if (yo >= reg_size) begin
      res = make_write(1'b0, '0, '0, 1'b1);
      return 1'b1;
    end
    walk_first_col = x;
    walk_col = x;
    walk_row = y;
    walk_end_col = (x + w > reg_width) ? reg_width : x + w;
    walk_end_row = (y + h > reg_height) ? reg_height : y + h;
    walk_color = color;
    walk_row_off = yo;
    walk_busy = 1'b1;
    return 1'b0;
  endfunction

  function automatic bit predict_engine(input crfe_pkg::op_t op, input logic [63:0] x,
                                        input logic [63:0] y, input logic [63:0] w,
                                        input logic [63:0] h, input logic [31:0] color,
                                        output fb_write_t res);
    logic [63:0] off;
    logic [63:0] nxt;
    logic [63:0] yo;
    bit fits;
    bit done;
    res = '0;
    off = '0;
    fits = 1'b0;
    done = 1'b0;
    case (op)
      crfe_pkg::OP_PIXEL: begin
        if (walk_busy) return 1'b0;
        if (gate_open() && x < reg_width && y < reg_height)
          fits = pixel_fit(y * reg_stride, x, off);
        res = make_write(fits, off, color, 1'b1);
        return 1'b1;
      end
      crfe_pkg::OP_RECT: return begin_walk(x, y, w, h, color, res);
      crfe_pkg::OP_FILL: return begin_walk('0, '0, reg_width, reg_height, color, res);
      default: begin
        if (!walk_busy) return 1'b0;
        fits = pixel_fit(walk_row_off, walk_col, off);
        if (fits && walk_col + 1 < walk_end_col) begin
          walk_col = walk_col + 1;
        end else begin
          nxt = walk_row + 1;
          if (nxt >= walk_end_row) begin
            done = 1'b1;
          end else begin
            yo = nxt * reg_stride;
            if (yo >= reg_size) begin
              done = 1'b1;
            end else begin
              walk_row = nxt;
              walk_col = walk_first_col;
              walk_row_off = yo;
            end
          end
        end
        if (done) walk_busy = 1'b0;
        res = make_write(fits && gate_open(), off, walk_color, done);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, results_seen, got, want);
  endtask

  always @(posedge clk) begin : monitor
    fb_write_t res;
    fb_write_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crfe_pkg::REG_BASE_ADDRESS:    reg_base = {16'b0, cfg_data[47:0]};
          crfe_pkg::REG_BUFFER_SIZE:     reg_size = {24'b0, cfg_data[39:0]};
          crfe_pkg::REG_SCREEN_WIDTH:    reg_width = {48'b0, cfg_data[15:0]};
          crfe_pkg::REG_SCREEN_HEIGHT:   reg_height = {48'b0, cfg_data[15:0]};
          crfe_pkg::REG_ROW_STRIDE:      reg_stride = {40'b0, cfg_data[23:0]};
          crfe_pkg::REG_PIXEL_BYTES:     reg_bpp = {60'b0, cfg_data[3:0]};
          crfe_pkg::REG_CONFIGURED:      reg_configured = cfg_data[0];
          crfe_pkg::REG_WRITES_ALLOWED:  reg_allowed = cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        words_in++;
        if (predict_engine(in_tuser, 64'(in_tdata[15:0]), 64'(in_tdata[31:16]),
                           64'(in_tdata[47:32]), 64'(in_tdata[63:48]),
                           in_tdata[95:64], res))
          expected_writes.push_back(res);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_writes.size() == 0) begin
          flag_mismatch("unexpected result", out_tdata[63:0], '0);
        end else begin
          want = expected_writes.pop_front();
          if (want.wr) writes_seen++;
          if (want.done) walks_ended++;
          if (out_tdata[0] !== want.wr)
            flag_mismatch("write_valid", 64'(out_tdata[0]), 64'(want.wr));
          if (out_tdata[ADDR_LSB +: 48] !== want.addr)
            flag_mismatch("address", 64'(out_tdata[ADDR_LSB +: 48]), 64'(want.addr));
          if (out_tdata[DATA_LSB +: 32] !== want.data)
            flag_mismatch("data", 64'(out_tdata[DATA_LSB +: 32]), 64'(want.data));
          if (out_tdata[CNT_LSB +: 3] !== want.cnt)
            flag_mismatch("byte_count", 64'(out_tdata[CNT_LSB +: 3]), 64'(want.cnt));
          if (out_tlast !== want.done)
            flag_mismatch("done_res", 64'(out_tlast), 64'(want.done));
        end
      end
    end
  end

  always @(negedge clk) begin : sender
    fill_cmd_t cmd;
    if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd = cmd_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cmd.op;
        in_tdata <= {cmd.color, cmd.h, cmd.w, cmd.y, cmd.x};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        pat_left = $urandom_range(16, 96);
      end
      out_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      pat_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_writes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_item(input crfe_pkg::op_t op, input logic [15:0] x,
                          input logic [15:0] y, input logic [15:0] w,
                          input logic [15:0] h, input logic [31:0] color);
    cmd_queue.push_back('{op, x, y, w, h, color});
    items_queued++;
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) add_item(crfe_pkg::OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), $urandom);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || expected_writes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    while (walk_busy) begin
      add_ticks(16);
      drain();
    end
  endtask

  task automatic cfg_write(input crfe_pkg::reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [47:0] base, input logic [39:0] size,
                            input logic [15:0] sw, input logic [15:0] sh,
                            input logic [23:0] stride, input logic [3:0] bpp,
                            input bit conf, input bit allow);
    cfg_write(crfe_pkg::REG_BASE_ADDRESS, CFG_W'(base));
    cfg_write(crfe_pkg::REG_BUFFER_SIZE, CFG_W'(size));
    cfg_write(crfe_pkg::REG_SCREEN_WIDTH, CFG_W'(sw));
    cfg_write(crfe_pkg::REG_SCREEN_HEIGHT, CFG_W'(sh));
    cfg_write(crfe_pkg::REG_ROW_STRIDE, CFG_W'(stride));
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(bpp));
    cfg_write(crfe_pkg::REG_CONFIGURED, CFG_W'(conf));
    cfg_write(crfe_pkg::REG_WRITES_ALLOWED, CFG_W'(allow));
    settings_used++;
  endtask

  function automatic int unsigned walk_ticks(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] w, input logic [63:0] h);
    logic [63:0] cols;
    logic [63:0] rows;
    if (x >= reg_width || y >= reg_height) return 0;
    cols = (x + w > reg_width) ? reg_width - x : w;
    rows = (y + h > reg_height) ? reg_height - y : h;
    return int'(32'(cols * rows));
  endfunction

  initial begin : stimulus
    logic [63:0] r64;
    logic [47:0] base;
    logic [39:0] size;
    logic [23:0] stride;
    logic [15:0] sw;
    logic [15:0] sh;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [3:0] bpp;
    bit wide;
    int unsigned pick;
    int unsigned ticks;
    int unsigned phase_end;
    int unsigned random_start;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the engine is unconfigured, so every command is refused.
    add_item(crfe_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h1234_5678);
    add_item(crfe_pkg::OP_RECT, 1, 1, 2, 2, 32'h8765_4321);
    add_item(crfe_pkg::OP_FILL, 0, 0, 0, 0, 32'h0F0F_0F0F);
    add_item(crfe_pkg::OP_TICK, 0, 0, 0, 0, 32'h0);
    settle();

    // Full-size screen over a tiny buffer near the top of the address space.
    set_config(48'hFFFF_FFFF_FFF0, 40'd64, 16'hFFFF, 16'hFFFF, 24'd16, 4'd4, 1'b1, 1'b1);
    add_item(crfe_pkg::OP_PIXEL, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(crfe_pkg::OP_PIXEL, 3, 3, 0, 0, 32'hA5A5_5A5A);
    add_item(crfe_pkg::OP_PIXEL, 16'hFFFF, 16'hFFFF, 0, 0, 32'h1111_1111);
    add_item(crfe_pkg::OP_PIXEL, 0, 4, 0, 0, 32'h2222_2222);
    add_item(crfe_pkg::OP_PIXEL, 16, 0, 0, 0, 32'h3333_3333);
    add_item(crfe_pkg::OP_RECT, 2, 0, 0, 5, 32'h4444_4444);
    add_item(crfe_pkg::OP_RECT, 2, 0, 5, 0, 32'h5555_5555);
    add_item(crfe_pkg::OP_RECT, 0, 4, 2, 2, 32'h6666_6666);
    add_item(crfe_pkg::OP_RECT, 16'hFFFE, 1, 16'hFFFF, 16'hFFFF, 32'h7777_7777);
    add_item(crfe_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h8888_8888);
    add_item(crfe_pkg::OP_RECT, 0, 0, 1, 1, 32'h9999_9999);
    add_item(crfe_pkg::OP_FILL, 0, 0, 0, 0, 32'hAAAA_AAAA);
    add_ticks(4);
    settle();

    // Small screen, widest stride, largest buffer, byte pixels.
    set_config(48'h1000, 40'hFF_FFFF_FFFF, 16'd5, 16'd3, 24'hFF_FFFF, 4'd1, 1'b1, 1'b1);
    add_item(crfe_pkg::OP_FILL, 0, 0, 0, 0, 32'hC3A5_9617);
    add_ticks(walk_ticks(0, 0, reg_width, reg_height) + 1);
    settle();
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(4'd2));
    add_item(crfe_pkg::OP_PIXEL, 4, 2, 0, 0, 32'hDEAD_BEEF);
    drain();
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(4'd8));
    add_item(crfe_pkg::OP_PIXEL, 4, 2, 0, 0, 32'hDEAD_BEEF);
    drain();
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(4'd0));
    add_item(crfe_pkg::OP_PIXEL, 1, 1, 0, 0, 32'hDEAD_BEEF);
    drain();
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(4'd15));
    add_item(crfe_pkg::OP_RECT, 0, 0, 2, 1, 32'h0BAD_F00D);
    add_ticks(2);
    settle();

    // The interlock is closed in the middle of a walk and opened again.
    cfg_write(crfe_pkg::REG_PIXEL_BYTES, CFG_W'(4'd4));
    add_item(crfe_pkg::OP_RECT, 1, 0, 3, 2, 32'hCAFE_F00D);
    add_ticks(2);
    drain();
    cfg_write(crfe_pkg::REG_WRITES_ALLOWED, CFG_W'(1'b0));
    add_ticks(2);
    drain();
    cfg_write(crfe_pkg::REG_WRITES_ALLOWED, CFG_W'(1'b1));
    settle();

    cfg_write(crfe_pkg::REG_CONFIGURED, CFG_W'(1'b0));
    add_item(crfe_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h1357_9BDF);
    add_item(crfe_pkg::OP_RECT, 0, 0, 2, 2, 32'h2468_ACE0);
    drain();
    cfg_write(crfe_pkg::REG_CONFIGURED, CFG_W'(1'b1));
    cfg_write(crfe_pkg::REG_WRITES_ALLOWED, CFG_W'(1'b0));
    add_item(crfe_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h1357_9BDF);
    add_item(crfe_pkg::OP_FILL, 0, 0, 0, 0, 32'h2468_ACE0);
    drain();

    // Random register settings, each followed by a stream of commands and walks.
    random_start = items_queued;
    hold_req = 1'b1;
    while (items_queued - random_start < 700) begin
      wide = ($urandom_range(0, 9) >= 7);
      if (wide) begin
        sw = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
        sh = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
      end else begin
        sw = 16'($urandom_range(0, 24));
        sh = 16'($urandom_range(0, 16));
      end
      bpp = ($urandom_range(0, 9) < 8) ? 4'(4'd1 << $urandom_range(0, 2)) :
                                         4'($urandom_range(0, 15));
      pick = $urandom_range(0, 3);
      if (pick == 0) stride = '0;
      else if (pick == 1) stride = 24'(sw) * 24'(bpp);
      else if (pick == 2) stride = 24'($urandom_range(1, 4096));
      else stride = 24'hFF_FFFF;
      r64 = {$urandom, $urandom};
      pick = $urandom_range(0, 3);
      if (pick == 0) size = 40'hFF_FFFF_FFFF;
      else if (pick == 1) size = '0;
      else if (pick == 2) size = 40'(r64 % ({40'b0, stride} * 64'(sh) + 64'd2));
      else size = r64[39:0];
      r64 = {$urandom, $urandom};
      base = ($urandom_range(0, 7) == 0) ? 48'hFFFF_FFFF_FFFF : r64[47:0];
      set_config(base, size, sw, sh, stride, bpp,
                 $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);

      phase_end = items_queued + $urandom_range(60, 80);
      while (items_queued < phase_end) begin
        pick = $urandom_range(0, 99);
        x = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                          16'($urandom_range(0, sw + (wide ? 0 : 1)));
        y = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                          16'($urandom_range(0, sh + (wide ? 0 : 1)));
        if (pick < 45) begin
          w = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8));
          h = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8));
          if (w == 16'hFFFF && sw > 8) x = 16'(sw - $urandom_range(1, 8));
          if (h == 16'hFFFF && sh > 8) y = 16'(sh - $urandom_range(1, 8));
          add_item(crfe_pkg::OP_RECT, x, y, w, h, $urandom);
          ticks = walk_ticks(64'(x), 64'(y), 64'(w), 64'(h));
          if ($urandom_range(0, 6) == 0) begin
            add_ticks(ticks / 2);
            add_item(crfe_pkg::op_t'($urandom_range(0, 2)), x, y, w, h, $urandom);
            add_ticks(ticks - ticks / 2 + $urandom_range(0, 2));
          end else begin
            add_ticks(ticks + $urandom_range(0, 2));
          end
        end else if (pick < 60 && !wide) begin
          add_item(crfe_pkg::OP_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom);
          add_ticks(walk_ticks(0, 0, reg_width, reg_height) + $urandom_range(0, 2));
        end else if (pick < 92) begin
          add_item(crfe_pkg::OP_PIXEL, x, y, 16'($urandom), 16'($urandom), $urandom);
        end else begin
          add_ticks(1);
        end
      end
      settle();
    end

    drain();
    $display("Checked %0d results (%0d memory writes, %0d command ends) from %0d words.",
             results_seen, writes_seen, walks_ended, words_in);
    $display("Register settings exercised: %0d; mismatches: %0d.", settings_used, mismatches);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
